@@ design/afdsc_pkg.sv @@
// ----------------------------------------------------------------------------
// afdsc_pkg
// Types, codes and helpers shared by the frame digit-sum checker.
// ----------------------------------------------------------------------------
package afdsc_pkg;

	localparam int BYTE_W   = 8;
	localparam int KIND_W   = 2;
	localparam int SUM_W    = 10;
	localparam int NUM_W    = 7;
	localparam int FRAME_W  = 16;

	localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;

	typedef enum logic [KIND_W-1:0] {
		KIND_MSG   = 2'd0,
		KIND_OK    = 2'd1,
		KIND_ERROR = 2'd2
	} afdsc_kind_t;

	typedef struct packed {
		afdsc_kind_t        kind;
		logic [BYTE_W-1:0]  msg_byte;
		logic [SUM_W-1:0]   digit_sum;
		logic [NUM_W-1:0]   check_value;
		logic [BYTE_W-1:0]  frame_header;
		logic [FRAME_W-1:0] frame_number;
		logic               first_frame;
	} afdsc_result_t;

	function automatic logic is_digit(input logic [BYTE_W-1:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	// low four bits of a digit character are its value
	function automatic logic [3:0] digit_value(input logic [BYTE_W-1:0] c);
		return is_digit(c) ? c[3:0] : 4'd0;
	endfunction

	// acc * 10 + d, kept to the number width
	function automatic logic [NUM_W-1:0] number_next(input logic [NUM_W-1:0] acc,
			input logic [3:0] d);
		logic [NUM_W+3:0] wide;
		wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{NUM_W{1'b0}}, d};
		return wide[NUM_W-1:0];
	endfunction

endpackage

@@ design/afdsc_if.sv @@
// ----------------------------------------------------------------------------
// afdsc_byte_if / afdsc_result_if
// Valid/ready channels for the input byte stream and the result stream.
// ----------------------------------------------------------------------------
interface afdsc_byte_if;
	import afdsc_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface afdsc_result_if;
	import afdsc_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [BYTE_W-1:0]  msg_byte;
	logic [SUM_W-1:0]   digit_sum;
	logic [NUM_W-1:0]   check_value;
	logic [BYTE_W-1:0]  frame_header;
	logic [FRAME_W-1:0] frame_number;
	logic               first_frame;

	modport source (output valid, output kind, output msg_byte, output digit_sum,
		output check_value, output frame_header, output frame_number,
		output first_frame, input ready);
	modport sink   (input valid, input kind, input msg_byte, input digit_sum,
		input check_value, input frame_header, input frame_number,
		input first_frame, output ready);
endinterface

@@ design/ascii_frame_digit_sum_checker.sv @@
// ----------------------------------------------------------------------------
// ascii_frame_digit_sum_checker
// Parses framed ASCII bytes, passes message bytes out and reports each
// frame's digit-sum check against its decimal checksum.
// ----------------------------------------------------------------------------
// One byte is taken every clock cycle unless the result queue is full. Each
// accepted byte updates the frame parser; a message byte or the second
// checksum character yields one result, which enters a two-entry queue and
// is offered on the result channel from the next cycle on. The byte channel
// stalls only while the queue holds two untaken results. No sweep after reset.
module ascii_frame_digit_sum_checker import afdsc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	afdsc_byte_if.sink     bytes,
	afdsc_result_if.source results
);

	logic          accept;
	logic          res_push;
	afdsc_result_t res;
	logic          buf_full;
	logic          buf_valid;
	afdsc_result_t buf_data;

	assign bytes.ready = !buf_full;
	assign accept      = bytes.valid && !buf_full;

	afdsc_frame_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (bytes.in_byte),
		.res_push (res_push),
		.res      (res)
	);

	afdsc_out_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.pop       (buf_valid && results.ready),
		.valid     (buf_valid),
		.full      (buf_full),
		.data      (buf_data)
	);

	assign results.valid        = buf_valid;
	assign results.kind         = buf_data.kind;
	assign results.msg_byte     = buf_data.msg_byte;
	assign results.digit_sum    = buf_data.digit_sum;
	assign results.check_value  = buf_data.check_value;
	assign results.frame_header = buf_data.frame_header;
	assign results.frame_number = buf_data.frame_number;
	assign results.first_frame  = buf_data.first_frame;

endmodule

@@ design/afdsc_frame_fsm.sv @@
// ----------------------------------------------------------------------------
// afdsc_frame_fsm
// Frame parser: tracks the field position, length, digit sum and checksum,
// and forms at most one result for each accepted byte.
// ----------------------------------------------------------------------------
module afdsc_frame_fsm import afdsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              res_push,
	output afdsc_result_t     res
);

	typedef enum logic [5:0] {
		ST_HEADER = 6'b000001,
		ST_LEN1   = 6'b000010,
		ST_LEN2   = 6'b000100,
		ST_MSG    = 6'b001000,
		ST_CHK1   = 6'b010000,
		ST_CHK2   = 6'b100000
	} afdsc_state_t;

	afdsc_state_t       state_q, state_d;
	logic [BYTE_W-1:0]  header_q, header_d;
	logic [NUM_W-1:0]   length_q, length_d;
	logic               ended_q, ended_d;
	logic [NUM_W-1:0]   seen_q, seen_d;
	logic [SUM_W-1:0]   sum_q, sum_d;
	logic [NUM_W-1:0]   check_q, check_d;
	logic [FRAME_W-1:0] frames_q, frames_d;

	logic               digit;
	logic [3:0]         dval;
	logic [NUM_W-1:0]   len_next;
	logic [NUM_W-1:0]   chk_next;
	logic [SUM_W-1:0]   sum_inc;
	logic [NUM_W-1:0]   seen_inc;
	logic [FRAME_W-1:0] frames_inc;

	assign digit      = is_digit(in_byte);
	assign dval       = digit_value(in_byte);
	assign len_next   = number_next(length_q, dval);
	assign chk_next   = number_next(check_q, dval);
	assign sum_inc    = sum_q + {{(SUM_W-4){1'b0}}, dval};
	assign seen_inc   = seen_q + {{(NUM_W-1){1'b0}}, 1'b1};
	assign frames_inc = frames_q + {{(FRAME_W-1){1'b0}}, 1'b1};

	always_comb begin
		state_d  = state_q;
		header_d = header_q;
		length_d = length_q;
		ended_d  = ended_q;
		seen_d   = seen_q;
		sum_d    = sum_q;
		check_d  = check_q;
		frames_d = frames_q;
		res_push = 1'b0;

		res.kind         = KIND_MSG;
		res.msg_byte     = in_byte;
		res.digit_sum    = sum_inc;
		res.check_value  = '0;
		res.frame_header = header_q;
		res.frame_number = frames_q;
		res.first_frame  = 1'b0;

		case (state_q)
			ST_LEN1: begin
				ended_d  = !digit;
				length_d = digit ? {3'b000, dval} : '0;
				state_d  = ST_LEN2;
			end
			ST_LEN2: begin
				if (!ended_q && digit) begin
					length_d = len_next;
				end else begin
					ended_d = 1'b1;
				end
				seen_d  = '0;
				sum_d   = '0;
				state_d = ((!ended_q && digit) ? (len_next == '0) : (length_q == '0))
					? ST_CHK1 : ST_MSG;
			end
			ST_MSG: begin
				res_push = 1'b1;
				sum_d    = sum_inc;
				seen_d   = seen_inc;
				if (seen_inc >= length_q) begin
					state_d = ST_CHK1;
				end
			end
			ST_CHK1: begin
				ended_d = !digit;
				check_d = digit ? {3'b000, dval} : '0;
				state_d = ST_CHK2;
			end
			ST_CHK2: begin
				res_push = 1'b1;
				if (!ended_q && digit) begin
					check_d = chk_next;
				end else begin
					ended_d = 1'b1;
				end
				frames_d         = frames_inc;
				res.kind         = (sum_q == {{(SUM_W-NUM_W){1'b0}}, check_d})
					? KIND_OK : KIND_ERROR;
				res.msg_byte     = '0;
				res.digit_sum    = sum_q;
				res.check_value  = check_d;
				res.frame_number = frames_inc;
				res.first_frame  = (frames_inc == {{(FRAME_W-1){1'b0}}, 1'b1});
				state_d          = ST_HEADER;
			end
			default: begin
				// skip line breaks between frames
				if (in_byte != CHAR_CR && in_byte != CHAR_LF) begin
					header_d = in_byte;
					sum_d    = '0;
					seen_d   = '0;
					state_d  = ST_LEN1;
				end else begin
					state_d = ST_HEADER;
				end
			end
		endcase

		res_push = res_push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_HEADER;
			header_q <= '0;
			length_q <= '0;
			ended_q  <= 1'b0;
			seen_q   <= '0;
			sum_q    <= '0;
			check_q  <= '0;
			frames_q <= '0;
		end else if (accept) begin
			state_q  <= state_d;
			header_q <= header_d;
			length_q <= length_d;
			ended_q  <= ended_d;
			seen_q   <= seen_d;
			sum_q    <= sum_d;
			check_q  <= check_d;
			frames_q <= frames_d;
		end
	end

endmodule

@@ design/afdsc_out_buf.sv @@
// ----------------------------------------------------------------------------
// afdsc_out_buf
// Two-entry result queue that decouples the parser from the result channel.
// ----------------------------------------------------------------------------
module afdsc_out_buf import afdsc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  afdsc_result_t push_data,
	input  logic          pop,
	output logic          valid,
	output logic          full,
	output afdsc_result_t data
);

	afdsc_result_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign valid = (count_q != 2'd0);
	assign full  = (count_q == 2'd2);
	assign data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame digit-sum checker. Streams framed ASCII
// bytes (directed frames, and random frames with line noise and
// broken numbers), predicts every message-byte and status result from its
// own parser model, and compares results in order under sender and receiver
// backpressure.
// ----------------------------------------------------------------------------
module tb_top;
	import afdsc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int          MAX_REPORTS = 40;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_LEN1   = 3'd1,
		PH_LEN2   = 3'd2,
		PH_MSG    = 3'd3,
		PH_CHK1   = 3'd4,
		PH_CHK2   = 3'd5
	} parse_phase_t;

	logic clk;
	logic arst_n;

	afdsc_byte_if   byte_ch();
	afdsc_result_if result_ch();

	ascii_frame_digit_sum_checker u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_ch),
		.results (result_ch)
	);

	// parser state of the predictor
	parse_phase_t        parse_ph    = PH_HEADER;
	logic [BYTE_W-1:0]   hdr_q       = '0;
	logic [NUM_W-1:0]    len_q       = '0;
	bit                  num_done    = 1'b0;
	logic [NUM_W-1:0]    msg_count   = '0;
	logic [SUM_W-1:0]    sum_q       = '0;
	logic [NUM_W-1:0]    chk_q       = '0;
	logic [FRAME_W-1:0]  frame_count = '0;

	afdsc_result_t frame_out_q[$];

	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          send_calm      = 0;
	int          recv_calm      = 0;
	int          bytes_sent     = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit char_is_digit(input logic [BYTE_W-1:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	// atoi-style: a non-digit ends the number for good
	function automatic logic [NUM_W-1:0] accumulate_decimal(input logic [NUM_W-1:0] acc,
			input logic [BYTE_W-1:0] c);
		int t;
		if (!num_done && char_is_digit(c)) begin
			t = acc * 10 + (c - CHAR_ZERO);
			return t[NUM_W-1:0];
		end
		num_done = 1'b1;
		return acc;
	endfunction

	function automatic bit parse_frame_byte(input logic [BYTE_W-1:0] c,
			output afdsc_result_t r);
		r = '0;
		case (parse_ph)
			PH_LEN1: begin
				num_done = 1'b0;
				len_q    = accumulate_decimal('0, c);
				parse_ph = PH_LEN2;
				return 1'b0;
			end
			PH_LEN2: begin
				len_q     = accumulate_decimal(len_q, c);
				msg_count = '0;
				sum_q     = '0;
				parse_ph  = (len_q == 0) ? PH_CHK1 : PH_MSG;
				return 1'b0;
			end
			PH_MSG: begin
				if (char_is_digit(c))
					sum_q = sum_q + SUM_W'(c - CHAR_ZERO);
				msg_count = msg_count + 1'b1;
				if (msg_count >= len_q)
					parse_ph = PH_CHK1;
				r.kind         = KIND_MSG;
				r.msg_byte     = c;
				r.digit_sum    = sum_q;
				r.frame_header = hdr_q;
				r.frame_number = frame_count;
				return 1'b1;
			end
			PH_CHK1: begin
				num_done = 1'b0;
				chk_q    = accumulate_decimal('0, c);
				parse_ph = PH_CHK2;
				return 1'b0;
			end
			PH_CHK2: begin
				chk_q       = accumulate_decimal(chk_q, c);
				frame_count = frame_count + 1'b1;
				r.kind         = (sum_q == SUM_W'(chk_q)) ? KIND_OK : KIND_ERROR;
				r.digit_sum    = sum_q;
				r.check_value  = chk_q;
				r.frame_header = hdr_q;
				r.frame_number = frame_count;
				r.first_frame  = (frame_count == 1);
				parse_ph = PH_HEADER;
				return 1'b1;
			end
			default: begin
				// skip line breaks between frames
				if (c == CHAR_CR || c == CHAR_LF)
					return 1'b0;
				hdr_q     = c;
				sum_q     = '0;
				msg_count = '0;
				parse_ph  = PH_LEN1;
				return 1'b0;
			end
		endcase
	endfunction

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		afdsc_result_t want;
		afdsc_result_t nxt;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (frame_out_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: expected no result, actual kind %0d digit_sum %0d",
							$time, result_ch.kind, result_ch.digit_sum);
				end else begin
					want = frame_out_q.pop_front();
					check_field("kind", want.kind, result_ch.kind);
					check_field("msg_byte", want.msg_byte, result_ch.msg_byte);
					check_field("digit_sum", want.digit_sum, result_ch.digit_sum);
					check_field("check_value", want.check_value, result_ch.check_value);
					check_field("frame_header", want.frame_header, result_ch.frame_header);
					check_field("frame_number", want.frame_number, result_ch.frame_number);
					check_field("first_frame", want.first_frame, result_ch.first_frame);
				end
			end
			if (byte_ch.valid && byte_ch.ready && parse_frame_byte(byte_ch.in_byte, nxt))
				frame_out_q.push_back(nxt);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: random stalls with occasional calm stretches
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (recv_calm > 0) begin
				recv_calm--;
				result_ch.ready <= 1'b1;
			end else if ($urandom_range(0, 99) == 0) begin
				recv_calm = $urandom_range(10, 60);
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	function automatic bit sender_pauses();
		if (send_calm > 0) begin
			send_calm--;
			return 1'b0;
		end
		if ($urandom_range(0, 99) == 0) begin
			send_calm = $urandom_range(10, 60);
			return 1'b0;
		end
		return $urandom_range(0, 99) < send_idle_pct;
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		@(negedge clk);
		while (sender_pauses()) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid   <= 1'b1;
		byte_ch.in_byte <= b;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	function automatic logic [BYTE_W-1:0] digit_char(input int d);
		return BYTE_W'(CHAR_ZERO + d);
	endfunction

	function automatic logic [BYTE_W-1:0] non_digit_char();
		logic [BYTE_W-1:0] c;
		do
			c = BYTE_W'($urandom_range(0, 255));
		while (char_is_digit(c));
		return c;
	endfunction

	task automatic send_number(input int v);
		send_byte(digit_char(v / 10));
		send_byte(digit_char(v % 10));
	endtask

	task automatic send_random_frame();
		logic [BYTE_W-1:0] hdr;
		logic [BYTE_W-1:0] b;
		int len;
		int sum;
		do
			hdr = BYTE_W'($urandom_range(0, 255));
		while (hdr == CHAR_CR || hdr == CHAR_LF);
		send_byte(hdr);

		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5, 6: begin
				len = $urandom_range(0, 12);
				send_number(len);
			end
			7: begin
				len = $urandom_range(13, 99);
				send_number(len);
			end
			8: begin
				len = $urandom_range(0, 9);
				send_byte(digit_char(len));
				send_byte(non_digit_char());
			end
			default: begin
				len = 0;
				send_byte(non_digit_char());
				send_byte(BYTE_W'($urandom_range(0, 255)));
			end
		endcase

		sum = 0;
		repeat (len) begin
			if ($urandom_range(0, 1))
				b = digit_char($urandom_range(0, 9));
			else
				b = BYTE_W'($urandom_range(0, 255));
			if (char_is_digit(b))
				sum += b - CHAR_ZERO;
			send_byte(b);
		end

		// a matching checksum half the time, else a random or malformed one
		case ($urandom_range(0, 3))
			0, 1: send_number((sum <= 99) ? sum : $urandom_range(0, 99));
			2: send_number($urandom_range(0, 99));
			default: begin
				if ($urandom_range(0, 1)) begin
					send_byte(digit_char($urandom_range(0, 9)));
					send_byte(non_digit_char());
				end else begin
					send_byte(non_digit_char());
					send_byte(BYTE_W'($urandom_range(0, 255)));
				end
			end
		endcase
	endtask

	task automatic send_line_noise();
		case ($urandom_range(0, 19))
			0, 1, 2, 3: begin
				repeat ($urandom_range(1, 3))
					send_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
			end
			4: begin
				// stray bytes knock the parser out of step
				repeat ($urandom_range(1, 4))
					send_byte(BYTE_W'($urandom_range(0, 255)));
			end
			default: ;
		endcase
	endtask

	task automatic test_directed_frames();
		logic [BYTE_W-1:0] seq[$];
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		seq = '{CHAR_CR, CHAR_LF,
			8'hFF, "0", "4", "9", 8'h00, 8'hFF, CHAR_CR, "0", "9",
			8'h00, "x", "7", "7", "x",
			"0", "1", "y", "5", "5", CHAR_LF};
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	task automatic test_random_stream(input int idle_pct, input int stall_pct,
			input int n_bytes);
		int start;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			send_random_frame();
			send_line_noise();
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		byte_ch.valid   = 1'b0;
		byte_ch.in_byte = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_frames();
		test_random_stream(0, 0, 150);
		test_random_stream(85, 0, 150);
		test_random_stream(0, 85, 150);
		test_random_stream(18, 18, 150);

		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (frame_out_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
